// ===== src/scf_pkg.sv =====
// Package for the SPI command frame builder: frame types, CRC-8 constants
// and the byte-wise CRC update function. No dependencies.
package scf_pkg;

  localparam logic [7:0] CrcPoly   = 8'h1D;
  localparam logic [7:0] CrcInit   = 8'hFF;
  localparam logic [7:0] CrcXorOut = 8'hFF;
  localparam logic [7:0] CrcTopBit = 8'h80;

  localparam int FifoDepth = 2;
  localparam int PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    BYTE_ADDR    = 2'd0,
    BYTE_DATA_HI = 2'd1,
    BYTE_DATA_LO = 2'd2,
    BYTE_CRC     = 2'd3
  } byte_sel_e;

  typedef struct packed {
    logic [7:0] addr_byte;
    logic [7:0] data_hi;
    logic [7:0] data_lo;
  } frame_body_t;

  typedef struct packed {
    logic        valid;
    frame_body_t body;
  } queue_head_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CrcTopBit) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/scf_cmd_if.sv =====
// Command channel carrying one register access per transfer.
// No dependencies.
interface scf_cmd_if;
  logic        valid;
  logic        ready;
  logic        is_read;
  logic [6:0]  reg_addr;
  logic [15:0] write_data;

  modport source (output valid, output is_read, output reg_addr, output write_data,
                  input ready);
  modport sink (input valid, input is_read, input reg_addr, input write_data,
                output ready);
endinterface

// ===== src/scf_byte_if.sv =====
// Frame byte channel carrying one SPI frame byte per transfer.
// No dependencies.
interface scf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== src/scf_front.sv =====
// Front end: accepts register accesses and builds the three frame body bytes.
// Depends on scf_pkg and scf_cmd_if.
module scf_front
  import scf_pkg::*;
(
  scf_cmd_if.sink     cmd_i,
  input  logic        full_i,
  output logic        push_o,
  output frame_body_t body_o
);

  logic [15:0] data;

  // A read sends zero data bytes whatever the write data holds.
  assign data             = cmd_i.is_read ? 16'h0000 : cmd_i.write_data;
  assign body_o.addr_byte = {cmd_i.reg_addr, cmd_i.is_read};
  assign body_o.data_hi   = data[15:8];
  assign body_o.data_lo   = data[7:0];

  assign cmd_i.ready = !full_i;
  assign push_o      = cmd_i.valid && !full_i;

endmodule

// ===== src/scf_fifo.sv =====
// Short queue of frame bodies between the front and back ends.
// Depends on scf_pkg.
module scf_fifo
  import scf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  frame_body_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output queue_head_t head_o
);

  frame_body_t     mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntW'(FifoDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.body  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/scf_back.sv =====
// Back end: serializes the queued frame body, runs the CRC-8 one byte per
// cycle unless stalled and appends the CRC byte. Depends on scf_pkg and scf_byte_if.
module scf_back
  import scf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        pop_o,
  scf_byte_if.source  frame_o
);

  byte_sel_e  sel_q, sel_d;
  logic [7:0] crc_q, crc_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       advance;
  logic [7:0] cur_byte;

  assign advance = head_i.valid && (!out_valid_q || frame_o.ready);
  assign pop_o   = advance && (sel_q == BYTE_CRC);

  always_comb begin
    case (sel_q)
      BYTE_ADDR:    cur_byte = head_i.body.addr_byte;
      BYTE_DATA_HI: cur_byte = head_i.body.data_hi;
      BYTE_DATA_LO: cur_byte = head_i.body.data_lo;
      BYTE_CRC:     cur_byte = crc_q ^ CrcXorOut;
      default:      cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    sel_d       = sel_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && !frame_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = (sel_q == BYTE_CRC);
      if (sel_q == BYTE_CRC) begin
        sel_d = BYTE_ADDR;
        crc_d = CrcInit;
      end else begin
        sel_d = byte_sel_e'(sel_q + 2'd1);
        crc_d = crc_update(crc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= BYTE_ADDR;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.last_byte  = out_last_q;

endmodule

// ===== src/spi_command_frame_crc8_core.sv =====
// The first frame byte passes the queue and then the output byte register.
// Throughput: one frame byte per cycle while the receiver is ready and a frame is
// queued, set by the output byte register of the back end; an access is four bytes.
// A two-entry queue lets the front accept while the back still sends bytes.
// Reset clears the queue, the byte position, the CRC and the output valid.
module spi_command_frame_crc8_core
  import scf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  scf_cmd_if.sink    cmd_i,
  scf_byte_if.source frame_o
);

  logic        push;
  logic        full;
  logic        pop;
  frame_body_t body;
  queue_head_t head;

  scf_front u_front (
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push),
    .body_o (body)
  );

  scf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (body),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head)
  );

  scf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .frame_o (frame_o)
  );

endmodule
